>>> src/pshs_pkg.sv
// pshs_pkg: shared types and constants for the pipeline hazard stall scheduler
// holds the instruction and result word structs, opcode codes and cycle width
// no dependencies
`default_nettype none

package pshs_pkg;

	// width of every cycle counter and cycle field
	localparam int CYCLE_BITS = 16;
	localparam logic [CYCLE_BITS-1:0] CYCLE_MAX = {CYCLE_BITS{1'b1}};

	// instruction class codes; unused codes act as a plain reader
	localparam logic [2:0] OP_EMPTY  = 3'd0;
	localparam logic [2:0] OP_ALU    = 3'd1;
	localparam logic [2:0] OP_LOAD   = 3'd2;
	localparam logic [2:0] OP_BRANCH = 3'd3;
	localparam logic [2:0] OP_OTHER  = 3'd4;

	// minimum fetch distances behind a producer
	localparam int BRANCH_GAP = 2;
	localparam int LOAD_GAP   = 2;
	localparam int ALU_GAP    = 3;
	// fetch to writeback distance in a five-stage pipe
	localparam int WB_OFFSET  = 4;

	typedef logic [CYCLE_BITS-1:0] cyc_t;

	typedef struct packed {
		logic [2:0] op;
		logic [4:0] src_a;
		logic [4:0] src_b;
		logic [4:0] dest_r;
		logic       end_of_program;
	} in_word_t;

	typedef struct packed {
		cyc_t       fetch_cycle;
		logic [1:0] stalls;
		cyc_t       bubble_total;
		cyc_t       writeback_cycle;
	} out_word_t;

	// handshake between input stage and result register
	typedef struct packed {
		logic advance;
		logic slot_free;
	} flow_t;

endpackage

`default_nettype wire

>>> src/pshs_in_stage.sv
// pshs_in_stage: input register stage holding one instruction word
// depends on pshs_pkg
`default_nettype none

module pshs_in_stage (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  pshs_pkg::in_word_t in_word,
	input  wire               slot_free,
	output pshs_pkg::flow_t   flow,
	output pshs_pkg::in_word_t word_s1
);
	import pshs_pkg::*;

	logic valid_s1;

	// word moves on when the result register can take its result
	assign flow.advance   = valid_s1 & slot_free;
	assign flow.slot_free = slot_free;
	assign in_ready       = ~valid_s1 | flow.advance;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (flow.advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
	end

endmodule

`default_nettype wire

>>> src/pshs_core.sv
// pshs_core: hazard check, fetch scheduling and program state
// depends on pshs_pkg
`default_nettype none

module pshs_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_wr_en,
	input  wire                cfg_wr_data,
	input  pshs_pkg::in_word_t  word_s1,
	input  pshs_pkg::flow_t    flow,
	output pshs_pkg::out_word_t result
);
	import pshs_pkg::*;

	localparam int EXT_BITS = CYCLE_BITS + 2;
	typedef logic [EXT_BITS-1:0] ext_t;

	logic       fwd_on_q;
	cyc_t       next_free_q;
	cyc_t       bubbles_q;
	logic       prev_branch_q;
	logic       hist_writes_q [2];
	logic       hist_load_q   [2];
	logic [4:0] hist_dest_q   [2];
	cyc_t       hist_fetch_q  [2];

	ext_t                want;
	cyc_t                fetch;
	cyc_t                stall_diff;
	logic [CYCLE_BITS:0] bub_sum;
	logic [CYCLE_BITS:0] wb_sum;
	logic [CYCLE_BITS:0] nxt_sum;
	cyc_t                bub_next;
	cyc_t                wb_cycle;
	cyc_t                nxt_free;

	// earliest legal fetch cycle against branch and the two prior producers
	always_comb begin
		ext_t cand;
		want = {2'b00, next_free_q};
		cand = {2'b00, hist_fetch_q[0]} + ext_t'(BRANCH_GAP);
		if (prev_branch_q && cand > want) begin
			want = cand;
		end
		for (int k = 0; k < 2; k++) begin
			if (word_s1.op != OP_EMPTY && hist_writes_q[k] &&
			    (word_s1.src_a == hist_dest_q[k] || word_s1.src_b == hist_dest_q[k])) begin
				if (hist_load_q[k]) begin
					cand = {2'b00, hist_fetch_q[k]} + ext_t'(LOAD_GAP);
					if (cand > want) begin
						want = cand;
					end
				end else if (!fwd_on_q) begin
					cand = {2'b00, hist_fetch_q[k]} + ext_t'(ALU_GAP);
					if (cand > want) begin
						want = cand;
					end
				end
			end
		end
	end

	// saturation and derived counts
	always_comb begin
		fetch      = (want > {2'b00, CYCLE_MAX}) ? CYCLE_MAX : want[CYCLE_BITS-1:0];
		stall_diff = fetch - next_free_q;
		bub_sum    = {1'b0, bubbles_q} + {{(CYCLE_BITS-1){1'b0}}, stall_diff[1:0]};
		bub_next   = bub_sum[CYCLE_BITS] ? CYCLE_MAX : bub_sum[CYCLE_BITS-1:0];
		wb_sum     = {1'b0, fetch} + (CYCLE_BITS+1)'(WB_OFFSET);
		wb_cycle   = wb_sum[CYCLE_BITS] ? CYCLE_MAX : wb_sum[CYCLE_BITS-1:0];
		nxt_sum    = {1'b0, fetch} + (CYCLE_BITS+1)'(1);
		nxt_free   = nxt_sum[CYCLE_BITS] ? CYCLE_MAX : nxt_sum[CYCLE_BITS-1:0];
	end

	assign result.fetch_cycle     = fetch;
	assign result.stalls          = stall_diff[1:0];
	assign result.bubble_total    = bub_next;
	assign result.writeback_cycle = wb_cycle;

	// forwarding control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_on_q <= 1'b1;
		end else if (cfg_wr_en) begin
			fwd_on_q <= cfg_wr_data;
		end
	end

	// program state: counters and two-deep producer history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q   <= cyc_t'(1);
			bubbles_q     <= '0;
			prev_branch_q <= 1'b0;
			for (int k = 0; k < 2; k++) begin
				hist_writes_q[k] <= 1'b0;
				hist_load_q[k]   <= 1'b0;
				hist_dest_q[k]   <= '0;
				hist_fetch_q[k]  <= '0;
			end
		end else if (flow.advance) begin
			if (word_s1.end_of_program) begin
				next_free_q   <= cyc_t'(1);
				bubbles_q     <= '0;
				prev_branch_q <= 1'b0;
				for (int k = 0; k < 2; k++) begin
					hist_writes_q[k] <= 1'b0;
					hist_load_q[k]   <= 1'b0;
					hist_dest_q[k]   <= '0;
					hist_fetch_q[k]  <= '0;
				end
			end else begin
				next_free_q      <= nxt_free;
				bubbles_q        <= bub_next;
				prev_branch_q    <= (word_s1.op == OP_BRANCH);
				hist_writes_q[1] <= hist_writes_q[0];
				hist_load_q[1]   <= hist_load_q[0];
				hist_dest_q[1]   <= hist_dest_q[0];
				hist_fetch_q[1]  <= hist_fetch_q[0];
				hist_writes_q[0] <= (word_s1.op == OP_ALU) || (word_s1.op == OP_LOAD);
				hist_load_q[0]   <= (word_s1.op == OP_LOAD);
				hist_dest_q[0]   <= (word_s1.op == OP_LOAD) ? word_s1.src_b : word_s1.dest_r;
				hist_fetch_q[0]  <= fetch;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/pshs_out_reg.sv
// pshs_out_reg: result register holding one result word until taken
// depends on pshs_pkg
`default_nettype none

module pshs_out_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pshs_pkg::flow_t     flow,
	input  pshs_pkg::out_word_t result,
	output logic                slot_free,
	output logic                out_valid,
	input  wire                 out_ready,
	output pshs_pkg::out_word_t out_word
);
	import pshs_pkg::*;

	logic      valid_q;
	out_word_t word_q;

	// slot opens when empty or when the held word leaves this cycle
	assign slot_free = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (flow.advance) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (flow.advance) begin
			word_q <= result;
		end
	end

endmodule

`default_nettype wire

>>> src/pipeline_hazard_stall_scheduler.sv
// Five-stage pipeline hazard stall scheduler. Takes one instruction word per cycle in program
// order while out_ready is high and returns one result word per instruction: fetch cycle,
// stalls inserted, running bubble total and writeback cycle. A result passes through the input
// register, then the result register, and becomes visible once it is in the result register.
// Throughput is one word per cycle while out_ready stays high; the hazard core's counters and
// two-entry producer history update in the same cycle a word moves into the result register.
// While a finished result waits, the input register can still take one more word.
// cfg_wr_data sets forwarding (reset on); write it only while idle.
// End of program returns all scheduling state to its reset value after that word.
// depends on pshs_pkg, pshs_in_stage, pshs_core, pshs_out_reg
`default_nettype none

module pipeline_hazard_stall_scheduler (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  wire                 cfg_wr_data,
	input  wire                 in_valid,
	output logic                in_ready,
	input  pshs_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  wire                 out_ready,
	output pshs_pkg::out_word_t out_word
);
	import pshs_pkg::*;

	flow_t     flow;
	in_word_t  word_s1;
	out_word_t result;
	logic      slot_free;

	// input register
	pshs_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.slot_free (slot_free),
		.flow      (flow),
		.word_s1   (word_s1)
	);

	// hazard check and state
	pshs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.word_s1     (word_s1),
		.flow        (flow),
		.result      (result)
	);

	// result register
	pshs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.flow      (flow),
		.result    (result),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

>>> src/pshs_checker.sv
// pshs_checker: port-level checks on the hazard stall scheduler, bound to the top level
// depends on pshs_pkg and pipeline_hazard_stall_scheduler
`default_nettype none

module pshs_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 out_valid,
	input wire                 out_ready,
	input pshs_pkg::out_word_t out_word
);
	import pshs_pkg::*;

	localparam cyc_t WB_LIMIT = CYCLE_MAX - cyc_t'(WB_OFFSET);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// writeback cycle is fetch cycle plus WB_OFFSET unless pinned at the top
	a_wb_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.fetch_cycle <= WB_LIMIT |->
		out_word.writeback_cycle == out_word.fetch_cycle + cyc_t'(WB_OFFSET))
		else $error("writeback cycle not fetch plus four");

	// never more than two bubbles, and the total covers them
	a_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.stalls != 2'd3 &&
		out_word.bubble_total >= cyc_t'(out_word.stalls))
		else $error("stall count inconsistent");

	// fetch cycles start at one
	a_fetch_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.fetch_cycle != '0)
		else $error("fetch cycle zero");

endmodule

bind pipeline_hazard_stall_scheduler pshs_checker u_pshs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire
